@@ design/slri_pkg.sv @@
// Shared types and constants for the sorted value store.
// No dependencies; every other design file imports this package.
package slri_pkg;

    // Number of cells in the chain
    localparam int DEPTH = 16;
    // Width of the fill count (holds 0 .. DEPTH)
    localparam int USED_W = $clog2(DEPTH + 1);
    // Count reported when the store is full, low bits of DEPTH
    localparam logic [4:0] FULL_COUNT = 5'(DEPTH);

    // Command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    // One request transfer
    typedef struct packed {
        logic               cmd;
        logic signed [31:0] value;
    } request_t;

    // One response transfer
    typedef struct packed {
        status_t    status;
        logic [4:0] count;
    } response_t;

    // Operation broadcast to every cell
    typedef struct packed {
        logic do_insert;
        logic do_remove;
    } cell_ctrl_t;

endpackage

@@ design/slri_cell.sv @@
// One storage cell of the sorted chain: holds one entry and compares it to the key.
// Depends on slri_pkg for the broadcast control struct.
module slri_cell
    import slri_pkg::*;
(
    input  logic               clk,
    input  cell_ctrl_t         ctrl,
    input  logic signed [31:0] key,
    input  logic               occupied,
    input  logic               left_lt,
    input  logic signed [31:0] left_entry,
    input  logic signed [31:0] right_entry,
    output logic               lt,
    output logic               eq,
    output logic signed [31:0] entry
);

    logic signed [31:0] entry_reg;
    logic signed [31:0] entry_next;

    // Compare the stored entry with the key
    assign lt    = occupied && (entry_reg < key);
    assign eq    = occupied && (entry_reg == key);
    assign entry = entry_reg;

    // Keep, take the key, or shift from a neighbor
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.do_insert)
        begin
            if (!lt)
            begin
                entry_next = left_lt ? key : left_entry;
            end
        end
        else if (ctrl.do_remove)
        begin
            if (!lt)
            begin
                entry_next = right_entry;
            end
        end
    end

    // Hold the entry
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

@@ design/sorted_list_insert_remove.sv @@
// Sorted store of signed values: a chain of DEPTH compare-and-shift cells.
// Latency: the response appears on the cycle after the request transfer (done strobe).
// Throughput: one request per cycle; every cell compares and shifts in the same cycle.
// busy stays low; the receiver cannot stall, so no output queue is needed.
// Reset: rst_n clears the fill count and the done strobe; entry contents stay undefined.
module sorted_list_insert_remove
    import slri_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  request_t  request,
    output logic      done,
    output response_t response
);

    logic [USED_W-1:0]  used_reg;
    logic [USED_W-1:0]  used_next;
    logic               done_reg;
    response_t          response_reg;
    response_t          response_next;
    logic               accept;
    logic               full;
    logic               found;
    cell_ctrl_t         ctrl;
    logic [DEPTH-1:0]   lt;
    logic [DEPTH-1:0]   eq;
    logic signed [31:0] entry [DEPTH];
    logic [USED_W+4:0]  count_ext;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (used_reg == USED_W'(DEPTH));
    assign found  = |eq;

    // Decode the operation for the cells
    always_comb
    begin
        ctrl.do_insert = accept && (request.cmd == CMD_INSERT) && !full;
        ctrl.do_remove = accept && (request.cmd == CMD_REMOVE) && found;
    end

    // Build the cell chain
    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic               occ;
            logic               l_lt;
            logic signed [31:0] l_entry;
            logic signed [31:0] r_entry;

            assign occ = (USED_W'(i) < used_reg);
            if (i == 0)
            begin : g_first
                assign l_lt    = 1'b1;
                assign l_entry = request.value;
            end
            else
            begin : g_mid
                assign l_lt    = lt[i-1];
                assign l_entry = entry[i-1];
            end
            if (i == DEPTH - 1)
            begin : g_last
                assign r_entry = request.value;
            end
            else
            begin : g_inner
                assign r_entry = entry[i+1];
            end

            slri_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .key         (request.value),
                .occupied    (occ),
                .left_lt     (l_lt),
                .left_entry  (l_entry),
                .right_entry (r_entry),
                .lt          (lt[i]),
                .eq          (eq[i]),
                .entry       (entry[i])
            );
        end
    endgenerate

    // Advance the fill count and form the response
    always_comb
    begin
        used_next = used_reg;
        if (ctrl.do_insert)
        begin
            used_next = used_reg + USED_W'(1);
        end
        else if (ctrl.do_remove)
        begin
            used_next = used_reg - USED_W'(1);
        end
        if (request.cmd == CMD_INSERT)
        begin
            response_next.status = full ? ST_FULL : ST_DONE;
        end
        else
        begin
            response_next.status = found ? ST_DONE : ST_NOT_FOUND;
        end
        count_ext           = {5'b0, used_next};
        response_next.count = count_ext[4:0];
    end

    // Hold count and strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
            done_reg <= accept;
        end
    end

    // Register the response payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            response_reg <= response_next;
        end
    end

    assign done     = done_reg;
    assign response = response_reg;

endmodule

@@ design/slri_checker.sv @@
// Port-level checks for the sorted store, bound to the top level.
// Depends on slri_pkg for status codes, command codes and the full count.
module slri_checker
    import slri_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input request_t  request,
    input logic      done,
    input response_t response
);

    // Every transfer gives one response on the next cycle
    a_resp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("missing response after request transfer");

    // No response without a transfer
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> !done)
        else $error("response without request transfer");

    // A full status reports a full store
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && response.status == ST_FULL) |-> (response.count == FULL_COUNT))
        else $error("full status with wrong count");

    // An insert reports done or full, never not found
    a_status_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && request.cmd == CMD_INSERT) |=>
            (response.status == ST_DONE || response.status == ST_FULL))
        else $error("insert reported not found");

endmodule

bind sorted_list_insert_remove slri_checker u_slri_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .request  (request),
    .done     (done),
    .response (response)
);
